### hdl/obb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg: shared types and constants of the oriented-box overlap test
// Payload structs, configuration register codes and the axis set that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int NUM_AXES    = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] SEP_NONE = 4'(NUM_AXES);

  typedef logic [2:0][15:0] vec3_t;
  typedef logic [2:0][16:0] dvec3_t;

  typedef struct packed {
    logic [47:0] a_center;
    logic [47:0] b_center;
    logic [47:0] b_axis_x;
    logic [47:0] b_axis_y;
    logic [47:0] b_axis_z;
    logic [47:0] b_half_sizes;
  } in_item_t;

  typedef struct packed {
    logic       overlap;
    logic [3:0] separating_axis;
  } out_item_t;

  typedef struct packed {
    logic [47:0] a_axis_x;
    logic [47:0] a_axis_y;
    logic [47:0] a_axis_z;
    logic [47:0] a_half_sizes;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_A_AXIS_X     = 2'd0,
    CFG_A_AXIS_Y     = 2'd1,
    CFG_A_AXIS_Z     = 2'd2,
    CFG_A_HALF_SIZES = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][2:0][15:0] axis;
    dvec3_t                         d;
    vec3_t                          b_ext;
  } axis_set_t;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    mag16 = x[15] ? 16'(-x) : x;
  endfunction

endpackage

### hdl/obb_overlap_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_overlap_test_top: oriented-box overlap test, 15 separating axes
// Top level with the box A configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// The block takes one box pair per cycle while in_ready is high and returns
// one result per pair, in order. The front registers the cross-product
// multiplier products and the queue holds the axis sets; in the back,
// fifteen axis lanes each have their own projection multipliers, then the
// absolute dot sums, the radius scaling, the radius sum, the compare and
// the first-axis pick are registered in turn. Box A's axes and half
// extents must be written while no pair is in flight.
module obb_overlap_test_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  obb_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output obb_pkg::out_item_t  out_data
);

  obb_pkg::cfg_t      cfg_r, cfg_nxt;
  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  obb_pkg::axis_set_t push_data, pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (obb_pkg::cfg_index_t'(cfg_index))
        obb_pkg::CFG_A_AXIS_X:     cfg_nxt.a_axis_x     = cfg_wdata;
        obb_pkg::CFG_A_AXIS_Y:     cfg_nxt.a_axis_y     = cfg_wdata;
        obb_pkg::CFG_A_AXIS_Z:     cfg_nxt.a_axis_z     = cfg_wdata;
        obb_pkg::CFG_A_HALF_SIZES: cfg_nxt.a_half_sizes = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  obb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  obb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  obb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/obb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_front: input stage of the overlap test
// Accepts box pairs, forms the center offset and the nine cross-product axes
// and pushes the complete axis set into the queue.
// ----------------------------------------------------------------------------
module obb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  obb_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  obb_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output obb_pkg::axis_set_t push_data
);

  logic                 s1_v_r, s1_v_nxt;
  logic signed [31:0]   cp_r   [9][6];
  logic signed [31:0]   cp_nxt [9][6];
  obb_pkg::vec3_t       bax_r  [3];
  obb_pkg::dvec3_t      d_r, d_nxt;
  obb_pkg::vec3_t       bext_r, bext_nxt;
  obb_pkg::vec3_t       aax    [3];
  obb_pkg::vec3_t       bax_in [3];
  obb_pkg::vec3_t       ac, bc, be;
  logic                 accept;

  function automatic logic [15:0] sat_cross(input logic signed [31:0] p,
                                            input logic signed [31:0] q);
    logic signed [32:0] x;
    logic signed [18:0] f;
    x = 33'(p) - 33'(q);
    f = 19'(x >>> 14);
    if (f > 19'sd32767) begin
      sat_cross = 16'h7fff;
    end else if (f < -19'sd32768) begin
      sat_cross = 16'h8000;
    end else begin
      sat_cross = f[15:0];
    end
  endfunction

  assign aax[0]    = cfg.a_axis_x;
  assign aax[1]    = cfg.a_axis_y;
  assign aax[2]    = cfg.a_axis_z;
  assign bax_in[0] = in_data.b_axis_x;
  assign bax_in[1] = in_data.b_axis_y;
  assign bax_in[2] = in_data.b_axis_z;
  assign ac        = in_data.a_center;
  assign bc        = in_data.b_center;
  assign be        = in_data.b_half_sizes;

  assign in_ready   = !s1_v_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = s1_v_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cp_nxt[3*i+j][0] = $signed(aax[i][1]) * $signed(bax_in[j][2]);
        cp_nxt[3*i+j][1] = $signed(aax[i][2]) * $signed(bax_in[j][1]);
        cp_nxt[3*i+j][2] = $signed(aax[i][2]) * $signed(bax_in[j][0]);
        cp_nxt[3*i+j][3] = $signed(aax[i][0]) * $signed(bax_in[j][2]);
        cp_nxt[3*i+j][4] = $signed(aax[i][0]) * $signed(bax_in[j][1]);
        cp_nxt[3*i+j][5] = $signed(aax[i][1]) * $signed(bax_in[j][0]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      d_nxt[k]    = $signed({bc[k][15], bc[k]}) - $signed({ac[k][15], ac[k]});
      bext_nxt[k] = obb_pkg::mag16(be[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cp_r   <= cp_nxt;
      d_r    <= d_nxt;
      bext_r <= bext_nxt;
      for (int k = 0; k < 3; k++) begin
        bax_r[k] <= bax_in[k];
      end
    end
  end

  always_comb begin
    push_data.d     = d_r;
    push_data.b_ext = bext_r;
    for (int k = 0; k < 3; k++) begin
      push_data.axis[k]     = aax[k];
      push_data.axis[3 + k] = bax_r[k];
    end
    for (int n = 0; n < 9; n++) begin
      push_data.axis[6 + n][0] = sat_cross(cp_r[n][0], cp_r[n][1]);
      push_data.axis[6 + n][1] = sat_cross(cp_r[n][2], cp_r[n][3]);
      push_data.axis[6 + n][2] = sat_cross(cp_r[n][4], cp_r[n][5]);
    end
  end

endmodule

### hdl/obb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_queue: short queue between front and back
// Two-entry register queue that holds complete axis sets.
// ----------------------------------------------------------------------------
module obb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  obb_pkg::axis_set_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output obb_pkg::axis_set_t  pop_data
);

  obb_pkg::axis_set_t mem_r [obb_pkg::QUEUE_DEPTH];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               push, pop;

  assign push_ready = count_r != 2'(obb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/obb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_back: projection pipeline of the overlap test
// Fifteen axis lanes project the offset and both boxes, compare distance
// against the radius sum and pick the first separating axis.
// ----------------------------------------------------------------------------
module obb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  obb_pkg::cfg_t       cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  obb_pkg::axis_set_t  pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output obb_pkg::out_item_t  out_data
);

  localparam int N = obb_pkg::NUM_AXES;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic r1, r2, r3, r4, r5, r_out;

  logic signed [32:0] pd_r  [N][3];
  logic signed [32:0] pd_nxt[N][3];
  logic signed [31:0] pa_r  [N][3][3];
  logic signed [31:0] pa_nxt[N][3][3];
  logic signed [31:0] pb_r  [N][3][3];
  logic signed [31:0] pb_nxt[N][3][3];
  obb_pkg::vec3_t     be1_r, be2_r;

  logic [32:0]        dd_r   [N];
  logic [32:0]        dd_nxt [N];
  logic [31:0]        ra_r   [N][3];
  logic [31:0]        ra_nxt [N][3];
  logic [31:0]        rb_r   [N][3];
  logic [31:0]        rb_nxt [N][3];

  logic [46:0]        dist3_r [N];
  logic [47:0]        qa_r    [N][3];
  logic [47:0]        qa_nxt  [N][3];
  logic [47:0]        qb_r    [N][3];
  logic [47:0]        qb_nxt  [N][3];

  logic [46:0]        dist4_r [N];
  logic [49:0]        rsum_r  [N];
  logic [49:0]        rsum_nxt[N];

  logic [N-1:0]       flag_r, flag_nxt;
  obb_pkg::out_item_t out_data_r, out_data_nxt;

  obb_pkg::vec3_t     aax[3];
  obb_pkg::vec3_t     ae;

  function automatic logic [32:0] abs_dot_d(input logic signed [32:0] a,
                                            input logic signed [32:0] b,
                                            input logic signed [32:0] c);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b) + 35'(c);
    abs_dot_d = s[34] ? 33'(-s) : s[32:0];
  endfunction

  function automatic logic [31:0] abs_dot(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic signed [31:0] c);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b) + 34'(c);
    abs_dot = s[33] ? 32'(-s) : s[31:0];
  endfunction

  assign aax[0] = cfg.a_axis_x;
  assign aax[1] = cfg.a_axis_y;
  assign aax[2] = cfg.a_axis_z;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ae[k] = obb_pkg::mag16(cfg.a_half_sizes[16*k +: 16]);
    end
  end

  assign r_out     = !out_v_r || out_ready;
  assign r5        = !v5_r || r_out;
  assign r4        = !v4_r || r5;
  assign r3        = !v3_r || r4;
  assign r2        = !v2_r || r3;
  assign r1        = !v1_r || r2;
  assign pop_ready = r1;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int n = 0; n < N; n++) begin
      for (int m = 0; m < 3; m++) begin
        pd_nxt[n][m] = $signed(pop_data.axis[n][m]) * $signed(pop_data.d[m]);
        for (int k = 0; k < 3; k++) begin
          pa_nxt[n][k][m] = $signed(pop_data.axis[n][m]) * $signed(aax[k][m]);
          pb_nxt[n][k][m] = $signed(pop_data.axis[n][m])
                          * $signed(pop_data.axis[3 + k][m]);
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      dd_nxt[n] = abs_dot_d(pd_r[n][0], pd_r[n][1], pd_r[n][2]);
      for (int k = 0; k < 3; k++) begin
        ra_nxt[n][k] = abs_dot(pa_r[n][k][0], pa_r[n][k][1], pa_r[n][k][2]);
        rb_nxt[n][k] = abs_dot(pb_r[n][k][0], pb_r[n][k][1], pb_r[n][k][2]);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      for (int k = 0; k < 3; k++) begin
        qa_nxt[n][k] = 48'(ra_r[n][k]) * 48'(ae[k]);
        qb_nxt[n][k] = 48'(rb_r[n][k]) * 48'(be2_r[k]);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      rsum_nxt[n] = 50'(qa_r[n][0]) + 50'(qa_r[n][1]) + 50'(qa_r[n][2])
                  + 50'(qb_r[n][0]) + 50'(qb_r[n][1]) + 50'(qb_r[n][2]);
      flag_nxt[n] = {3'b000, dist4_r[n]} > rsum_r[n];
    end
  end

  always_comb begin
    out_data_nxt.separating_axis = obb_pkg::SEP_NONE;
    for (int n = N - 1; n >= 0; n--) begin
      if (flag_r[n]) begin
        out_data_nxt.separating_axis = 4'(n);
      end
    end
    out_data_nxt.overlap = ~|flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (r1) begin
        v1_r <= pop_valid;
      end
      if (r2) begin
        v2_r <= v1_r;
      end
      if (r3) begin
        v3_r <= v2_r;
      end
      if (r4) begin
        v4_r <= v3_r;
      end
      if (r5) begin
        v5_r <= v4_r;
      end
      if (r_out) begin
        out_v_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      pd_r  <= pd_nxt;
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      be1_r <= pop_data.b_ext;
    end
    if (r2) begin
      dd_r  <= dd_nxt;
      ra_r  <= ra_nxt;
      rb_r  <= rb_nxt;
      be2_r <= be1_r;
    end
    if (r3) begin
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
      for (int n = 0; n < N; n++) begin
        dist3_r[n] <= {dd_r[n], 14'b0};
      end
    end
    if (r4) begin
      rsum_r  <= rsum_nxt;
      dist4_r <= dist3_r;
    end
    if (r5) begin
      flag_r <= flag_nxt;
    end
    if (r_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r.overlap ==
                 (out_data_r.separating_axis == obb_pkg::SEP_NONE)))
    else $error("overlap flag disagrees with separating axis code");

  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> v1_r)
    else $error("popped axis set did not enter the first stage");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !r_out) |=> v5_r)
    else $error("stalled compare stage lost its item");

endmodule
